### design/hztm_pkg.sv
// ----------------------------------------------------------------------------
// Heater zone thermal model package
// Shared constants, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package hztm_pkg;

	localparam int ZONES    = 15;
	localparam int ZONE_W   = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int TEMP_W   = 19;
	localparam int MUL_A_W  = 19;
	localparam int MUL_B_W  = 18;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	localparam logic [TEMP_W-1:0] FULL_SCALE = 19'd409600;
	localparam logic [MUL_B_W-1:0] RECIP_25  = 18'd5243;
	localparam logic [MUL_B_W-1:0] RECIP_100 = 18'd167773;
	localparam logic [15:0] READ_OFFSET      = 16'd10;
	localparam logic [15:0] READ_NO_ZONE     = 16'hFFFF;

	localparam logic [7:0] DEF_BASE_STEP      = 8'd3;
	localparam logic [7:0] DEF_APPROACH_COEF  = 8'd16;
	localparam logic [TEMP_W-1:0] DEF_FLOOR   = 19'd34000;

	typedef enum logic [1:0] {
		REG_BASE_STEP = 2'd0,
		REG_COEF      = 2'd1,
		REG_FLOOR     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_HEATER = 3'd1,
		OP_MASTER = 3'd2,
		OP_SELECT = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCALE,
		ST_RECIP,
		ST_APPLY,
		ST_RD_FETCH,
		ST_RD_DIV,
		ST_RD_OUT
	} state_t;

endpackage

### design/hztm_zone_mem.sv
// ----------------------------------------------------------------------------
// Zone temperature store
// One write port and one registered read port, with a valid bit per zone so
// that a zone never written since reset reads as zero.
// ----------------------------------------------------------------------------
module hztm_zone_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [hztm_pkg::ZONE_W-1:0]   wr_addr,
	input  logic [hztm_pkg::TEMP_W-1:0]   wr_data,
	input  logic [hztm_pkg::ZONE_W-1:0]   rd_addr,
	output logic [hztm_pkg::TEMP_W-1:0]   rd_data
);
	import hztm_pkg::*;

	logic [TEMP_W-1:0] mem_q [ZONES];
	logic [ZONES-1:0]  valid_q;
	logic [TEMP_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/heater_zone_thermal_model.sv
// ----------------------------------------------------------------------------
// Heater zone thermal model
// Command-driven model of heater zone temperatures with an APB register port.
// ----------------------------------------------------------------------------
// A tick walks the zones with one multiplier, four steps each. A read steps
// through fetch, divide and output states, its result strobed from a register
// after the output state; a read of an out-of-range zone is strobed on the next
// cycle. Other commands complete when accepted. Results cannot be stalled.
// Reset clears all zone temperatures, heater flags, the master enable and the
// selected zone, and loads the register defaults.
module heater_zone_thermal_model (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [7:0]  channel,
	input  logic        on_flag,
	output logic        valid,
	output logic [15:0] reading,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hztm_pkg::*;

	state_t state_q, state_d;

	logic [7:0]        base_q;
	logic [7:0]        coef_q;
	logic [TEMP_W-1:0] floor_q;

	logic [ZONES-1:0]  heater_q;
	logic              master_q;
	logic [7:0]        sel_q;
	logic [ZONE_W-1:0] idx_q;
	logic [PROD_W-1:0] prod_q;
	logic [TEMP_W-1:0] t_q;
	logic              neg_q;
	logic              heat_q;
	logic [15:0]       reading_q;
	logic              valid_q;

	logic              accept;
	logic              cfg_wr;
	logic              sel_in_range;
	logic              last_zone;
	logic              mem_we;
	logic [ZONE_W-1:0] rd_addr;
	logic [TEMP_W-1:0] rd_temp;
	logic [TEMP_W-1:0] new_temp;
	logic              heating;
	logic              over_full;
	logic [TEMP_W-1:0] mag;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0] product;
	logic [8:0]        quot;
	logic signed [20:0] step_sum;
	logic              emit;
	logic [15:0]       emit_val;

	assign accept       = start && !busy;
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign pready       = 1'b1;
	assign busy         = (state_q != ST_IDLE);
	assign sel_in_range = ({1'b0, sel_q} < 9'(ZONES));
	assign last_zone    = (idx_q == ZONE_W'(ZONES - 1));
	assign valid        = valid_q;
	assign reading      = reading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= DEF_BASE_STEP;
			coef_q  <= DEF_APPROACH_COEF;
			floor_q <= DEF_FLOOR;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_BASE_STEP: base_q  <= pwdata[7:0];
				REG_COEF:      coef_q  <= pwdata[7:0];
				REG_FLOOR:     floor_q <= pwdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_BASE_STEP: prdata = {24'd0, base_q};
			REG_COEF:      prdata = {24'd0, coef_q};
			REG_FLOOR:     prdata = {13'd0, floor_q};
			default:       prdata = '0;
		endcase
	end

	hztm_zone_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (idx_q),
		.wr_data (new_temp),
		.rd_addr (rd_addr),
		.rd_data (rd_temp)
	);

	assign heating   = heater_q[idx_q] && master_q;
	assign over_full = (rd_temp > FULL_SCALE);
	assign quot      = prod_q[25:17];
	assign product   = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_comb begin
		if (!heat_q) begin
			step_sum = $signed({2'b00, t_q}) - $signed({13'd0, base_q})
				- $signed({12'd0, quot});
		end else if (neg_q) begin
			step_sum = $signed({2'b00, t_q}) + $signed({13'd0, base_q})
				- $signed({12'd0, quot});
		end else begin
			step_sum = $signed({2'b00, t_q}) + $signed({13'd0, base_q})
				+ $signed({12'd0, quot});
		end
		if (step_sum > $signed({2'b00, FULL_SCALE})) begin
			new_temp = FULL_SCALE - TEMP_W'(1);
		end else if (step_sum < $signed({2'b00, floor_q})) begin
			new_temp = floor_q;
		end else begin
			new_temp = step_sum[TEMP_W-1:0];
		end
	end

	always_comb begin
		if (!heating) begin
			mag = rd_temp;
		end else if (over_full) begin
			mag = rd_temp - FULL_SCALE;
		end else begin
			mag = FULL_SCALE - rd_temp;
		end
	end

	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		rd_addr  = idx_q;
		mul_a    = '0;
		mul_b    = '0;
		emit     = 1'b0;
		emit_val = READ_NO_ZONE;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_TICK: state_d = ST_FETCH;
						OP_READ: begin
							if (sel_in_range) begin
								state_d = ST_RD_FETCH;
							end else begin
								emit = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FETCH: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				mul_a   = mag;
				mul_b   = {10'd0, coef_q};
				state_d = ST_RECIP;
			end
			ST_RECIP: begin
				mul_a   = {6'd0, prod_q[26:14]};
				mul_b   = RECIP_25;
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				mem_we  = 1'b1;
				state_d = last_zone ? ST_IDLE : ST_FETCH;
			end
			ST_RD_FETCH: begin
				rd_addr = sel_q[ZONE_W-1:0];
				state_d = ST_RD_DIV;
			end
			ST_RD_DIV: begin
				mul_a   = {2'b00, rd_temp[TEMP_W-1:2]};
				mul_b   = RECIP_100;
				state_d = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				emit     = 1'b1;
				emit_val = {3'd0, prod_q[34:22]} + READ_OFFSET;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q <= '0;
			master_q <= 1'b0;
			sel_q    <= '0;
			idx_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= emit;
			if (accept) begin
				case (op_t'(op))
					OP_TICK: idx_q <= '0;
					OP_HEATER: begin
						if ({1'b0, channel} < 9'(ZONES)) begin
							heater_q[channel[ZONE_W-1:0]] <= on_flag;
						end
					end
					OP_MASTER: master_q <= on_flag;
					OP_SELECT: sel_q    <= channel;
					default: ;
				endcase
			end
			if (state_q == ST_APPLY && !last_zone) begin
				idx_q <= idx_q + ZONE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			reading_q <= emit_val;
		end
		if (state_q == ST_SCALE || state_q == ST_RECIP || state_q == ST_RD_DIV) begin
			prod_q <= product;
		end
		if (state_q == ST_SCALE) begin
			t_q    <= rd_temp;
			neg_q  <= over_full;
			heat_q <= heating;
		end
	end

	a_apply_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> ({1'b0, idx_q} < (ZONE_W + 1)'(ZONES)))
		else $error("zone update outside the zone range");

	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ($past(state_q) == ST_RD_OUT ||
			($past(accept) && $past(op) == OP_READ)))
		else $error("result strobe without a read");

	a_no_zone_value: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && $past(state_q) == ST_IDLE) |-> (reading == READ_NO_ZONE))
		else $error("immediate read result is not the no-zone value");

	a_tick_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && last_zone) |=> (state_q == ST_IDLE))
		else $error("tick did not end after the last zone");

endmodule
